/* sv/wavetable_sine_oscillator_bank_core_assert.svh */
// Assertion macros for the wavetable sine oscillator bank.
// Used by the top level; needs signals named clock and reset in scope.
`ifndef WAVETABLE_SINE_OSCILLATOR_BANK_CORE_ASSERT_SVH
`define WAVETABLE_SINE_OSCILLATOR_BANK_CORE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define WSOB_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define WSOB_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* sv/wsob_pkg.sv */
// Shared types, sizes and the sine table for the oscillator bank.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package wsob_pkg;

   // Sizes. WAVE_POSITIONS is a power of two, so the phase wraps by truncation.
   localparam int NUM_CHANNELS   = 8;
   localparam int WAVE_POSITIONS = 64;
   localparam int FRACTION_BITS  = 16;

   localparam int CH_W     = 3;
   localparam int INC_W    = 22;
   localparam int SAMPLE_W = 16;
   localparam int POS_W    = $clog2(WAVE_POSITIONS);
   localparam int PHASE_W  = POS_W + FRACTION_BITS;
   localparam int ROM_AW   = 6;
   localparam int NUM_REGS = 2 ** CH_W;

   // Response queue depth; bounds the requests in flight.
   localparam int QDEPTH = 4;
   localparam int QPTR_W = $clog2(QDEPTH);
   localparam int QCNT_W = $clog2(QDEPTH + 1);

   // CSR address width: registers at byte address 4*i.
   localparam int CSR_AW = CH_W + 2;
   localparam int CSR_DW = 32;

   typedef struct packed {
      logic            valid;
      logic            live;
      logic [CH_W-1:0] ch;
   } tag_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] sample;
      logic [CH_W-1:0]            ch;
   } rsp_type;

   localparam logic [15:0] QUARTER_WAVE [0:16] = '{
      16'd0,     16'd3212,  16'd6393,  16'd9512,  16'd12539, 16'd15446,
      16'd18204, 16'd20787, 16'd23170, 16'd25329, 16'd27245, 16'd28898,
      16'd30273, 16'd31356, 16'd32137, 16'd32609, 16'd32767
   };

   // Full-wave sine entry built from the quarter-wave table.
   function automatic logic signed [SAMPLE_W-1:0] sine_entry(input logic [ROM_AW-1:0] k);
      logic [4:0]  q;
      logic [15:0] mag;
      q = k[4:0];
      if (q <= 5'd16) begin
         mag = QUARTER_WAVE[q];
      end else begin
         mag = QUARTER_WAVE[5'(6'd32 - {1'b0, q})];
      end
      return k[5] ? SAMPLE_W'(-$signed(mag)) : $signed(mag);
   endfunction

   // Map a table position onto the 64-entry ROM: floor(pos * 64 / WAVE_POSITIONS).
   function automatic logic [ROM_AW-1:0] rom_index(input logic [POS_W-1:0] pos);
      logic [POS_W+ROM_AW-1:0] t;
      t = {pos, ROM_AW'(0)};
      return t[POS_W +: ROM_AW];
   endfunction

endpackage

/* sv/wavetable_sine_oscillator_bank_core.sv */
// Wavetable sine oscillator bank: each request names a channel and returns one
// interpolated Q1.15 sine sample for it, then advances that channel's Q6.16
// phase by its increment register (CSR at byte address 4*channel). One request
// is taken every cycle while req_stall is low. Each taken request passes stage
// 1 and stage 2 and is then pushed into the response queue, raising rsp_valid.
// The rate is set by the single phase RAM, read when a request is taken and
// written in the cycle after, with the previous update forwarded. A four-entry
// response queue bounds the requests in flight: while results wait on
// rsp_stall, requests keep flowing until four are in flight, then req_stall
// holds them. req_stall is also high during reset. Depends on wsob_pkg.
`timescale 1ns / 1ps

module wavetable_sine_oscillator_bank_core
   import wsob_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   // request channel
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [CH_W-1:0]            req_channel_sel,
   // result channel
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic signed [SAMPLE_W-1:0] rsp_sample_out,
   output logic [CH_W-1:0]            rsp_channel_out,
   // configuration port
   input  logic                       csr_psel,
   input  logic                       csr_penable,
   input  logic                       csr_pwrite,
   input  logic [CSR_AW-1:0]          csr_paddr,
   input  logic [CSR_DW-1:0]          csr_pwdata,
   output logic [CSR_DW-1:0]          csr_prdata,
   output logic                       csr_pready
);

`include "wavetable_sine_oscillator_bank_core_assert.svh"

   logic [INC_W-1:0]   inc_ff [NUM_REGS];
   logic [CH_W-1:0]    csr_index;
   logic               csr_write;

   logic               req_accept;
   tag_type            s1_ff, s1_in;
   tag_type            s2_ff;
   logic [PHASE_W-1:0] s2_phase_ff;

   logic [PHASE_W-1:0] ram_rd_data;
   logic [PHASE_W-1:0] phase_cur;
   logic [PHASE_W-1:0] phase_new;
   logic               phase_wr;

   logic signed [SAMPLE_W-1:0] interp_sample;
   rsp_type            push_data;
   rsp_type            q_head;
   logic [QCNT_W-1:0]  q_count;
   logic [QCNT_W-1:0]  inflight;
   logic               rsp_pop;

   // ---------------------------------------------------------------- CSR
   // Decode by word address; pready stays high so the access phase never waits.
   assign csr_index  = csr_paddr[CSR_AW-1:2];
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign csr_prdata = CSR_DW'(inc_ff[csr_index]);

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_REGS; i++) begin
            inc_ff[i] <= '0;
         end
      end else if (csr_write) begin
         inc_ff[csr_index] <= csr_pwdata[INC_W-1:0];
      end
   end

   // ---------------------------------------------------------------- admit
   // Hold requests once every queue slot is promised to an item in flight,
   // and throughout reset.
   assign inflight   = QCNT_W'(s1_ff.valid) + QCNT_W'(s2_ff.valid) + q_count;
   assign req_stall  = reset || (inflight >= QCNT_W'(QDEPTH));
   assign req_accept = req_valid && !req_stall;

   always_comb begin
      s1_in.valid = req_accept;
      s1_in.live  = int'(req_channel_sel) < NUM_CHANNELS;
      s1_in.ch    = req_channel_sel;
   end

   // ---------------------------------------------------------------- phase RMW
   // Read the phase as the request is taken; it lands with the item in stage 1.
   wsob_phase_ram u_phase_ram (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (req_accept),
      .rd_addr (req_channel_sel),
      .rd_data (ram_rd_data),
      .wr_en   (phase_wr),
      .wr_addr (s1_ff.ch),
      .wr_data (phase_new)
   );

   // The item one stage ahead writes at the edge the read is taken, so its
   // update is not in the RAM data yet: forward it on a channel match.
   always_comb begin
      if (s2_ff.valid && s2_ff.live && (s2_ff.ch == s1_ff.ch)) begin
         phase_cur = s2_phase_ff;
      end else begin
         phase_cur = ram_rd_data;
      end
      phase_new = phase_cur + PHASE_W'(inc_ff[s1_ff.ch]);
      phase_wr  = s1_ff.valid && s1_ff.live;
   end

   always_ff @(posedge clock) begin
      s2_phase_ff <= phase_new;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff <= '0;
         s2_ff <= '0;
      end else begin
         s1_ff <= s1_in;
         s2_ff <= s1_ff;
      end
   end

   // ---------------------------------------------------------------- sample
   wsob_interp u_interp (
      .clock  (clock),
      .phase  (phase_cur),
      .sample (interp_sample)
   );

   // Drop the sample of a channel outside the bank: it reads as zero.
   always_comb begin
      push_data.sample = s2_ff.live ? interp_sample : '0;
      push_data.ch     = s2_ff.ch;
   end

   // ---------------------------------------------------------------- results
   assign rsp_pop = rsp_valid && !rsp_stall;

   wsob_rsp_queue u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (s2_ff.valid),
      .push_data (push_data),
      .pop       (rsp_pop),
      .head      (q_head),
      .count     (q_count)
   );

   assign rsp_valid       = q_count != '0;
   assign rsp_sample_out  = q_head.sample;
   assign rsp_channel_out = q_head.ch;

   // ---------------------------------------------------------------- checks
   `WSOB_ASSERT_NOW(a_q_room, s2_ff.valid, q_count < QCNT_W'(QDEPTH), "response queue overflow")
   `WSOB_ASSERT_NOW(a_inflight_bound, 1'b1, inflight <= QCNT_W'(QDEPTH), "too many in flight")
   `WSOB_ASSERT_NEXT(a_req_kept, req_accept, s1_ff.valid && s1_ff.ch == $past(req_channel_sel), "lost")

endmodule

/* sv/wsob_phase_ram.sv */
// Phase store: one synchronous write port, one registered read port.
// Per-entry valid bits make never-written entries read as zero. Uses wsob_pkg.
`timescale 1ns / 1ps

module wsob_phase_ram
   import wsob_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               rd_en,
   input  logic [CH_W-1:0]    rd_addr,
   output logic [PHASE_W-1:0] rd_data,
   input  logic               wr_en,
   input  logic [CH_W-1:0]    wr_addr,
   input  logic [PHASE_W-1:0] wr_data
);

   logic [PHASE_W-1:0]  mem [NUM_REGS];
   logic [NUM_REGS-1:0] valid_ff;
   logic [PHASE_W-1:0]  rd_data_ff;
   logic                rd_valid_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         if (rd_en) begin
            rd_valid_ff <= valid_ff[rd_addr];
         end
      end
   end

   assign rd_data = rd_valid_ff ? rd_data_ff : '0;

endmodule

/* sv/wsob_interp.sv */
// Interpolator: ROM lookup of both neighbors, then one multiply and round.
// Uses wsob_pkg for sizes and the sine table.
`timescale 1ns / 1ps

module wsob_interp
   import wsob_pkg::*;
(
   input  logic                       clock,
   input  logic [PHASE_W-1:0]         phase,
   output logic signed [SAMPLE_W-1:0] sample
);

   localparam int PROD_W = SAMPLE_W + 1 + FRACTION_BITS + 1;
   localparam int ACC_W  = SAMPLE_W + FRACTION_BITS + 3;

   logic [POS_W-1:0]          pos;
   logic [POS_W-1:0]          pos_next;
   logic signed [SAMPLE_W-1:0] a_in, a_ff;
   logic signed [SAMPLE_W:0]   d_in, d_ff;
   logic [FRACTION_BITS-1:0]   frac_ff;
   logic signed [PROD_W-1:0]   prod;
   logic signed [ACC_W-1:0]    acc;

   // Look up both entries and take their difference.
   always_comb begin
      pos      = phase[FRACTION_BITS +: POS_W];
      pos_next = pos + POS_W'(1);
      a_in     = sine_entry(rom_index(pos));
      d_in     = (SAMPLE_W + 1)'(sine_entry(rom_index(pos_next)))
               - (SAMPLE_W + 1)'(a_in);
   end

   always_ff @(posedge clock) begin
      a_ff    <= a_in;
      d_ff    <= d_in;
      frac_ff <= phase[FRACTION_BITS-1:0];
   end

   // a*2^F + (b-a)*f, rounded to nearest with halves going up.
   always_comb begin
      prod   = PROD_W'(d_ff * $signed({1'b0, frac_ff}));
      acc    = (ACC_W'(a_ff) <<< FRACTION_BITS) + ACC_W'(prod)
             + (ACC_W'(1) <<< (FRACTION_BITS - 1));
      sample = acc[FRACTION_BITS +: SAMPLE_W];
   end

endmodule

/* sv/wsob_rsp_queue.sv */
// Response queue between the datapath and the result channel.
// Small register array with head read; uses wsob_pkg.
`timescale 1ns / 1ps

module wsob_rsp_queue
   import wsob_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  rsp_type           push_data,
   input  logic              pop,
   output rsp_type           head,
   output logic [QCNT_W-1:0] count
);

   rsp_type           entry_ff [QDEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff + QCNT_W'(push) - QCNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   assign head  = entry_ff[rd_ptr_ff];
   assign count = count_ff;

endmodule
